@@ src/arx_pkg.sv @@
// ----------------------------------------------------------------------------
// arx_pkg
// Shared types and constants for the ARX stream cipher block: item structs,
// state word constants, rotation amounts and configuration register indexes.
// ----------------------------------------------------------------------------
package arx_pkg;

	// state geometry
	localparam int unsigned NUM_WORDS   = 16;
	localparam int unsigned NUM_LANES   = 8;
	localparam int unsigned NUM_BYTES   = 64;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned CFG_ADDR_W  = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	// constant words in state words 0 to 3
	localparam logic [31:0] SIGMA_0 = 32'h6e6f654e;
	localparam logic [31:0] SIGMA_1 = 32'h656e6547;
	localparam logic [31:0] SIGMA_2 = 32'h43736973;
	localparam logic [31:0] SIGMA_3 = 32'h74707972;

	// quarter round rotation amounts
	localparam int unsigned ROT_A = 23;
	localparam int unsigned ROT_B = 19;
	localparam int unsigned ROT_C = 13;
	localparam int unsigned ROT_D = 7;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_0      = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_1      = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_2      = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_3      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_NONCE_LOW  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_NONCE_HIGH = 3'd5;

	// saturation point of the byte count
	localparam logic [COUNT_W-1:0] MAX_COUNT = 7'd64;

	typedef logic [NUM_WORDS-1:0][31:0] state_t;

	typedef struct packed {
		logic [31:0]        block_counter;
		logic [63:0]        data_0;
		logic [63:0]        data_1;
		logic [63:0]        data_2;
		logic [63:0]        data_3;
		logic [63:0]        data_4;
		logic [63:0]        data_5;
		logic [63:0]        data_6;
		logic [63:0]        data_7;
		logic [COUNT_W-1:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        out_0;
		logic [63:0]        out_1;
		logic [63:0]        out_2;
		logic [63:0]        out_3;
		logic [63:0]        out_4;
		logic [63:0]        out_5;
		logic [63:0]        out_6;
		logic [63:0]        out_7;
		logic [COUNT_W-1:0] out_count;
	} out_item_t;

endpackage

@@ src/arx_stream_cipher_block.sv @@
// ----------------------------------------------------------------------------
// arx_stream_cipher_block
// ARX block function with keystream XOR over a 64-byte data item.
// ----------------------------------------------------------------------------
// Usage:
// Key and nonce are written through cfg_we / cfg_addr / cfg_wdata; the user
// must write them only while the block is idle; the block does not enforce
// this. A write lands at the clock edge with cfg_we high. An item on in_data
// (block counter, eight 64-bit data words, byte count) is taken when
// in_valid and in_ready are both high. in_ready is high only while no item
// is in work: the block handles one item at a time. The accept edge loads
// the state, one half round (four quarter rounds on the shared round unit)
// runs per cycle, 2*DOUBLE_ROUNDS half rounds in all, and a final step adds
// the initial state, XORs the data and masks bytes beyond the count into the
// output register. The result waits in out_data with out_valid high until
// out_ready; a stalled receiver holds the block in its final step. Byte
// counts above 64 saturate to 64. Reset clears the key and nonce registers
// to zero and drops any item in work.
// ----------------------------------------------------------------------------
module arx_stream_cipher_block import arx_pkg::*; #(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	localparam int unsigned HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int unsigned RND_W = (HALF_ROUNDS > 1) ? $clog2(HALF_ROUNDS) : 1;
	localparam logic [RND_W-1:0] RND_LAST = RND_W'(HALF_ROUNDS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	logic [63:0]           key_q [4];
	logic [63:0]           nonce_low_q;
	logic [31:0]           nonce_high_q;
	logic [1:0]            state_q;
	logic [RND_W-1:0]      rnd_q;
	state_t                work_q;
	logic [31:0]           ctr_q;
	logic [NUM_LANES-1:0][63:0] data_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	state_t                round_nxt;
	state_t                init_w;
	logic                  in_fire;
	logic                  out_free;
	logic [COUNT_W-1:0]    cnt_sat;
	logic [NUM_LANES-1:0][63:0] res_w;

	// initial state from constants, key, counter and nonce
	function automatic state_t build_init(input logic [31:0] ctr, input logic [63:0] k0,
		input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3,
		input logic [63:0] nl, input logic [31:0] nh);
		state_t s;
		s[0]  = SIGMA_0;
		s[1]  = SIGMA_1;
		s[2]  = SIGMA_2;
		s[3]  = SIGMA_3;
		s[4]  = k0[31:0];
		s[5]  = k0[63:32];
		s[6]  = k1[31:0];
		s[7]  = k1[63:32];
		s[8]  = k2[31:0];
		s[9]  = k2[63:32];
		s[10] = k3[31:0];
		s[11] = k3[63:32];
		s[12] = ctr;
		s[13] = nl[31:0];
		s[14] = nl[63:32];
		s[15] = nh;
		build_init = s;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cnt_sat   = (in_data.byte_count > MAX_COUNT) ? MAX_COUNT : in_data.byte_count;

	assign init_w = build_init(ctr_q, key_q[0], key_q[1], key_q[2], key_q[3],
		nonce_low_q, nonce_high_q);

	// shared round unit, columns on even steps and diagonals on odd steps
	arx_round u_round (
		.st   (work_q),
		.diag (rnd_q[0]),
		.nxt  (round_nxt)
	);

	// feed-forward add, data xor and byte mask
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			res_w[i] = {work_q[2*i+1] + init_w[2*i+1], work_q[2*i] + init_w[2*i]} ^ data_q[i];
			for (int j = 0; j < 8; j++) begin
				if (COUNT_W'(8*i + j) >= cnt_q) begin
					res_w[i][8*j +: 8] = 8'd0;
				end
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				key_q[k] <= '0;
			end
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_KEY_0:      key_q[0]     <= cfg_wdata;
				REG_KEY_1:      key_q[1]     <= cfg_wdata;
				REG_KEY_2:      key_q[2]     <= cfg_wdata;
				REG_KEY_3:      key_q[3]     <= cfg_wdata;
				REG_NONCE_LOW:  nonce_low_q  <= cfg_wdata;
				REG_NONCE_HIGH: nonce_high_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set by the final step, cleared once the item is taken
			if (state_q == ST_FINAL && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					if (rnd_q == RND_LAST) begin
						state_q <= ST_FINAL;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working state and item payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			work_q <= build_init(in_data.block_counter, key_q[0], key_q[1], key_q[2],
				key_q[3], nonce_low_q, nonce_high_q);
			ctr_q     <= in_data.block_counter;
			data_q[0] <= in_data.data_0;
			data_q[1] <= in_data.data_1;
			data_q[2] <= in_data.data_2;
			data_q[3] <= in_data.data_3;
			data_q[4] <= in_data.data_4;
			data_q[5] <= in_data.data_5;
			data_q[6] <= in_data.data_6;
			data_q[7] <= in_data.data_7;
			cnt_q     <= cnt_sat;
		end else if (state_q == ST_ROUND) begin
			work_q <= round_nxt;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINAL && out_free) begin
			out_data_q.out_0     <= res_w[0];
			out_data_q.out_1     <= res_w[1];
			out_data_q.out_2     <= res_w[2];
			out_data_q.out_3     <= res_w[3];
			out_data_q.out_4     <= res_w[4];
			out_data_q.out_5     <= res_w[5];
			out_data_q.out_6     <= res_w[6];
			out_data_q.out_7     <= res_w[7];
			out_data_q.out_count <= cnt_q;
		end
	end

endmodule

@@ src/arx_round.sv @@
// ----------------------------------------------------------------------------
// arx_round
// One half round of the block function: four quarter rounds in parallel,
// on the columns or on the diagonals of the 16-word state.
// ----------------------------------------------------------------------------
module arx_round import arx_pkg::*; (
	input  state_t st,
	input  logic   diag,
	output state_t nxt
);

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// quarter round on four words, returned as {a, b, c, d}
	function automatic logic [127:0] qr(input logic [31:0] a_in, input logic [31:0] b_in,
		input logic [31:0] c_in, input logic [31:0] d_in);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		a = a_in;
		b = b_in;
		c = c_in;
		d = d_in;
		a = a + b; d = rotl(d ^ a, ROT_A);
		c = c + d; b = rotl(b ^ c, ROT_B);
		a = a + b; d = rotl(d ^ a, ROT_C);
		c = c + d; b = rotl(b ^ c, ROT_D);
		qr = {a, b, c, d};
	endfunction

	logic [1:0]   sh;
	logic [3:0]   ia [4];
	logic [3:0]   ib [4];
	logic [3:0]   ic [4];
	logic [3:0]   id [4];
	logic [127:0] res [4];

	// word selection: diagonals shift rows 1, 2 and 3 by one, two and three lanes
	assign sh = diag ? 2'd1 : 2'd0;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ia[i] = {2'd0, 2'(i)};
			ib[i] = {2'd1, 2'(2'(i) + sh)};
			ic[i] = {2'd2, 2'(2'(i) + {sh[0], 1'b0})};
			id[i] = {2'd3, 2'(2'(i) + {sh[0], sh[0]})};
			res[i] = qr(st[ia[i]], st[ib[i]], st[ic[i]], st[id[i]]);
		end
	end

	// scatter the four results back into the state
	always_comb begin
		nxt = st;
		for (int i = 0; i < 4; i++) begin
			nxt[ia[i]] = res[i][127:96];
			nxt[ib[i]] = res[i][95:64];
			nxt[ic[i]] = res[i][63:32];
			nxt[id[i]] = res[i][31:0];
		end
	end

endmodule

@@ sim/arx_stream_cipher_block_tb.sv @@
// ----------------------------------------------------------------------------
// arx_stream_cipher_block_tb
// Self-checking bench for the ARX stream cipher block. A local keystream
// predictor mirrors the key and nonce registers and computes the masked
// ciphertext of every accepted item. Results are checked in order, lane by
// lane. Directed items cover reset state, byte count edges, saturation, key
// extremes and ignored register indexes. Random traffic then runs under
// three sender/receiver idle mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module arx_stream_cipher_block_tb;
	import arx_pkg::*;

	localparam int CLK_PERIOD       = 8;
	localparam int RESET_CYCLES     = 9;
	localparam int DOUBLE_ROUNDS    = 10;
	localparam int SETTLE_CYCLES    = 2 * DOUBLE_ROUNDS + 4;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int MAX_REPORTS      = 10;
	localparam int RANDOM_PER_PHASE = 475;

	// indexes past the register list, writes there must have no effect
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	// shadow copy of the key and nonce registers
	logic [3:0][63:0] key_words;
	logic [63:0]      nonce_low_word;
	logic [31:0]      nonce_high_word;

	out_item_t cipher_expect_q[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_left;
	int        mismatch_count;
	int        blocks_sent;
	int        results_checked;

	arx_stream_cipher_block #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// keystream predictor
	function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t quarter_mix(state_t s, int unsigned a, int unsigned b,
			int unsigned c, int unsigned d);
		s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], ROT_A);
		s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], ROT_B);
		s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], ROT_C);
		s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], ROT_D);
		return s;
	endfunction

	function automatic out_item_t predict_cipher(in_item_t it);
		state_t                      init_s;
		state_t                      mix;
		logic [NUM_LANES-1:0][63:0]  data_lanes;
		logic [NUM_LANES-1:0][63:0]  res_lanes;
		logic [63:0]                 lane;
		logic [COUNT_W-1:0]          cnt;
		out_item_t                   r;
		init_s[0] = SIGMA_0;
		init_s[1] = SIGMA_1;
		init_s[2] = SIGMA_2;
		init_s[3] = SIGMA_3;
		for (int k = 0; k < 4; k++) begin
			init_s[4 + 2 * k] = key_words[k][31:0];
			init_s[5 + 2 * k] = key_words[k][63:32];
		end
		init_s[12] = it.block_counter;
		init_s[13] = nonce_low_word[31:0];
		init_s[14] = nonce_low_word[63:32];
		init_s[15] = nonce_high_word;
		mix = init_s;
		for (int rnd = 0; rnd < DOUBLE_ROUNDS; rnd++) begin
			mix = quarter_mix(mix, 0, 4, 8, 12);
			mix = quarter_mix(mix, 1, 5, 9, 13);
			mix = quarter_mix(mix, 2, 6, 10, 14);
			mix = quarter_mix(mix, 3, 7, 11, 15);
			mix = quarter_mix(mix, 0, 5, 10, 15);
			mix = quarter_mix(mix, 1, 6, 11, 12);
			mix = quarter_mix(mix, 2, 7, 8, 13);
			mix = quarter_mix(mix, 3, 4, 9, 14);
		end
		// counts above 64 saturate
		cnt = (it.byte_count > MAX_COUNT) ? MAX_COUNT : it.byte_count;
		data_lanes = {it.data_7, it.data_6, it.data_5, it.data_4,
			it.data_3, it.data_2, it.data_1, it.data_0};
		for (int i = 0; i < NUM_LANES; i++) begin
			lane = data_lanes[i] ^ {mix[2 * i + 1] + init_s[2 * i + 1],
				mix[2 * i] + init_s[2 * i]};
			for (int b = 0; b < 8; b++) begin
				if (8 * i + b >= cnt)
					lane[8 * b +: 8] = 8'h00;
			end
			res_lanes[i] = lane;
		end
		r.out_0 = res_lanes[0];
		r.out_1 = res_lanes[1];
		r.out_2 = res_lanes[2];
		r.out_3 = res_lanes[3];
		r.out_4 = res_lanes[4];
		r.out_5 = res_lanes[5];
		r.out_6 = res_lanes[6];
		r.out_7 = res_lanes[7];
		r.out_count = cnt;
		return r;
	endfunction

	// item builders
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t random_block();
		in_item_t it;
		int       sel;
		it.block_counter = $urandom;
		it.data_0 = rand64();
		it.data_1 = rand64();
		it.data_2 = rand64();
		it.data_3 = rand64();
		it.data_4 = rand64();
		it.data_5 = rand64();
		it.data_6 = rand64();
		it.data_7 = rand64();
		sel = $urandom_range(9);
		if (sel < 5)
			it.byte_count = MAX_COUNT;
		else if (sel < 8)
			it.byte_count = COUNT_W'($urandom_range(63));
		else if (sel == 8)
			it.byte_count = COUNT_W'($urandom_range(127, 65));
		else
			it.byte_count = COUNT_W'($urandom_range(127));
		return it;
	endfunction

	function automatic in_item_t fill_block(logic [31:0] counter, logic [63:0] pattern,
			logic [COUNT_W-1:0] count);
		in_item_t it;
		it.block_counter = counter;
		it.data_0 = pattern;
		it.data_1 = pattern;
		it.data_2 = pattern;
		it.data_3 = pattern;
		it.data_4 = pattern;
		it.data_5 = pattern;
		it.data_6 = pattern;
		it.data_7 = pattern;
		it.byte_count = count;
		return it;
	endfunction

	// register write, shadow copy follows the same decode
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_wdata = value;
		case (addr)
			REG_KEY_0:      key_words[0] = value;
			REG_KEY_1:      key_words[1] = value;
			REG_KEY_2:      key_words[2] = value;
			REG_KEY_3:      key_words[3] = value;
			REG_NONCE_LOW:  nonce_low_word = value;
			REG_NONCE_HIGH: nonce_high_word = value[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_config(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] n_lo,
			input logic [63:0] n_hi);
		write_reg(REG_KEY_0, k0);
		write_reg(REG_KEY_1, k1);
		write_reg(REG_KEY_2, k2);
		write_reg(REG_KEY_3, k3);
		write_reg(REG_NONCE_LOW, n_lo);
		write_reg(REG_NONCE_HIGH, n_hi);
	endtask

	// drop valid and wait until every expected result has come back
	task automatic settle_block();
		@(negedge clk);
		in_valid = 1'b0;
		while (cipher_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one item, with random gaps in front of it
	task automatic send_block(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do
			@(posedge clk);
		while (!in_ready);
		cipher_expect_q.push_back(predict_cipher(it));
		blocks_sent++;
	endtask

	// receiver: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cipher_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result item: %h", out_data);
			end else begin
				want = cipher_expect_q.pop_front();
				results_checked++;
				check_field("out_0", want.out_0, out_data.out_0);
				check_field("out_1", want.out_1, out_data.out_1);
				check_field("out_2", want.out_2, out_data.out_2);
				check_field("out_3", want.out_3, out_data.out_3);
				check_field("out_4", want.out_4, out_data.out_4);
				check_field("out_5", want.out_5, out_data.out_5);
				check_field("out_6", want.out_6, out_data.out_6);
				check_field("out_7", want.out_7, out_data.out_7);
				check_field("out_count", 64'(want.out_count), 64'(out_data.out_count));
			end
		end
	end

	// tests
	task automatic test_reset_config();
		send_block(fill_block(32'h0, 64'h0, MAX_COUNT));
		send_block(fill_block(32'hffff_ffff, '1, MAX_COUNT));
		settle_block();
	endtask

	task automatic test_byte_counts();
		int       count_points[10] = '{0, 1, 7, 8, 9, 31, 32, 56, 63, 64};
		in_item_t it;
		program_config(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
		for (int i = 0; i < 10; i++) begin
			it = random_block();
			it.byte_count = COUNT_W'(count_points[i]);
			send_block(it);
		end
	endtask

	task automatic test_saturation();
		in_item_t it;
		int       over_points[3] = '{65, 100, 127};
		for (int i = 0; i < 3; i++) begin
			it = random_block();
			it.byte_count = COUNT_W'(over_points[i]);
			send_block(it);
		end
		settle_block();
	endtask

	task automatic test_key_extremes();
		// upper half of the nonce_high write must be dropped
		program_config('1, '1, '1, '1, '1, '1);
		send_block(fill_block(32'h0, 64'h0, MAX_COUNT));
		send_block(fill_block(32'hffff_ffff, '1, MAX_COUNT));
		send_block(fill_block(32'h8000_0000, 64'h0123_4567_89ab_cdef, 7'd33));
		settle_block();
	endtask

	task automatic test_spare_registers();
		write_reg(REG_SPARE_6, rand64());
		write_reg(REG_SPARE_7, rand64());
		send_block(random_block());
		settle_block();
	endtask

	task automatic test_input_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 6; i++)
			send_block(random_block());
		settle_block();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input logic [63:0] k0);
		program_config(k0, rand64(), rand64(), rand64(), rand64(), rand64());
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < RANDOM_PER_PHASE; i++)
			send_block(random_block());
		settle_block();
	endtask

	// main sequence
	initial begin
		key_words = '0;
		nonce_low_word = '0;
		nonce_high_word = '0;
		hold_left = 0;
		mismatch_count = 0;
		blocks_sent = 0;
		results_checked = 0;
		send_idle_pct = 18;
		recv_idle_pct = 63;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_byte_counts();
		test_saturation();
		test_key_extremes();
		test_spare_registers();
		test_input_backpressure();
		test_random_traffic(18, 63, rand64());
		test_random_traffic(63, 18, '1);
		test_random_traffic(0, 0, rand64());

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d blocks: reset key, byte count edges, saturation,",
			blocks_sent);
		$display("key extremes, spare registers, a %0d-cycle hold-off, three idle mixes",
			HOLD_OFF_CYCLES);
		$display("%0d results checked", results_checked);
		if (mismatch_count == 0 && cipher_expect_q.size() == 0)
			$display("arx_stream_cipher_block_tb passed");
		else
			$display("arx_stream_cipher_block_tb failed");
		$finish;
	end

	// run limit
	initial begin
		#(CLK_PERIOD * 1000000);
		$display("arx_stream_cipher_block_tb failed");
		$finish;
	end

endmodule
